@@ hdl/osma_pkg.sv @@
// Package for the offset-scaled moving average block.
// Holds field widths, register indexes and the queue item type; no dependencies.
package osma_pkg;

   localparam int ADC_W     = 12;
   localparam int GAIN_W    = 16;
   localparam int CUR_W     = 28;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int DEPTH_DEF = 16;
   localparam int FILL_W_DEF = $clog2(DEPTH_DEF + 1);

   localparam logic [CSR_IDX_W-1:0] REG_ZERO_OFFSET = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN        = CSR_IDX_W'(1);

   typedef struct packed {
      logic             valid;
      logic [CUR_W-1:0] current;
   } cur_item_type;

endpackage

@@ hdl/osma_ifaces.sv @@
// Channel interfaces for the offset-scaled moving average block.
// Depends on osma_pkg for field widths.
interface osma_req_if;
   import osma_pkg::*;
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface osma_rsp_if #(
   parameter int FILL_W = osma_pkg::FILL_W_DEF
);
   import osma_pkg::*;
   logic              valid;
   logic              ready;
   logic [CUR_W-1:0]  sample_current;
   logic [CUR_W-1:0]  average_current;
   logic [FILL_W-1:0] fill_count;
   modport source (output valid, output sample_current, output average_current,
                   output fill_count, input ready);
   modport sink   (input valid, input sample_current, input average_current,
                   input fill_count, output ready);
endinterface

interface osma_csr_if;
   import osma_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/offset_scaled_moving_average_core.sv @@
// Top level of the offset-scaled moving average block.
// Depends on osma_pkg, the channel interfaces, osma_front, osma_queue and osma_back.
//
// Usage:
//   req_ch  : one raw 12-bit ADC sample per transaction (valid/ready).
//   rsp_ch  : one result per sample: the clamped current (Q16 amps), the
//             truncated mean of the stored currents and the fill count.
//   csr_ch  : register writes, index 0 = zero offset, index 1 = gain; always
//             ready, other indexes are ignored. Write only while idle.
// Timing:
//   The front end scales a sample in the cycle it is accepted and parks it in
//   a two-entry queue. The back end pops it, reads the ring entry about to be
//   overwritten (registered RAM read), updates the running total, then
//   divides by the fill count one quotient bit per cycle. The total is
//   28 + log2(DEPTH) bits wide (32 at DEPTH 16). The back end pops the next
//   sample only after the previous result has been taken from rsp_ch.
// Reset: synchronous, clears the registers, ring pointer, fill count, total
//   and queue; ring contents are not cleared and no clearing pass runs.
// Stall: a result holds on rsp_ch until taken; meanwhile up to two samples
//   are still accepted into the queue before req_ch.ready drops.
module offset_scaled_moving_average_core #(
   parameter int DEPTH = osma_pkg::DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   osma_req_if.sink   req_ch,
   osma_rsp_if.source rsp_ch,
   osma_csr_if.sink   csr_ch
);
   import osma_pkg::*;

   cur_item_type push;
   cur_item_type head;
   logic         q_full;
   logic         pop;

   // Accept and scale samples, hold configuration.
   osma_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .push   (push)
   );

   // Decouple the front end from the slow averaging path.
   osma_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .head  (head)
   );

   // Store, total, divide and present the result.
   osma_back #(.DEPTH(DEPTH)) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );
endmodule

@@ hdl/osma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/osma_front.sv @@
// Front end: configuration registers, sample acceptance, offset and gain scaling.
// Depends on osma_pkg and the channel interfaces.
module osma_front (
   input  logic                  clock,
   input  logic                  reset,
   osma_req_if.sink              req_ch,
   osma_csr_if.sink              csr_ch,
   input  logic                  q_full,
   output osma_pkg::cur_item_type push
);
   import osma_pkg::*;

   logic [ADC_W-1:0]  zero_offset_ff, zero_offset_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [ADC_W-1:0]  diff;
   logic [CUR_W-1:0]  current;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      zero_offset_in = zero_offset_ff;
      gain_in        = gain_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_ZERO_OFFSET: zero_offset_in = csr_ch.wdata[ADC_W-1:0];
            REG_GAIN:        gain_in        = csr_ch.wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= '0;
         gain_ff        <= '0;
      end else begin
         zero_offset_ff <= zero_offset_in;
         gain_ff        <= gain_in;
      end
   end

   // Clamp at or below the offset to zero; the product is exact in 28 bits.
   always_comb begin
      diff    = req_ch.adc_sample - zero_offset_ff;
      current = '0;
      if (req_ch.adc_sample > zero_offset_ff) begin
         current = CUR_W'(diff) * CUR_W'(gain_ff);
      end
   end

   assign req_ch.ready = !q_full;
   assign push.valid   = req_ch.valid && !q_full;
   assign push.current = current;
endmodule

@@ hdl/osma_queue.sv @@
// Two-entry queue between the front end and the averaging back end.
// Depends on osma_pkg for the item type.
module osma_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  osma_pkg::cur_item_type push,
   output logic                   full,
   input  logic                   pop,
   output osma_pkg::cur_item_type head
);
   import osma_pkg::*;

   logic [CUR_W-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full         = (count_ff == 2'd2);
   assign do_push      = push.valid && !full;
   assign do_pop       = pop && (count_ff != 2'd0);
   assign head.valid   = (count_ff != 2'd0);
   assign head.current = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.current;
      end
   end
endmodule

@@ hdl/osma_back.sv @@
// Back end: ring store, running total, serial divider and result register.
// Depends on osma_pkg, osma_ram and the response interface.
module osma_back #(
   parameter int DEPTH = osma_pkg::DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  osma_pkg::cur_item_type head,
   output logic                   pop,
   osma_rsp_if.source             rsp_ch
);
   import osma_pkg::*;

   localparam int AW     = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int TW     = CUR_W + $clog2(DEPTH);
   localparam int SW     = $clog2(TW);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [FILL_W-1:0] count_ff, count_in;
   logic [TW-1:0]     total_ff, total_in;
   logic [CUR_W-1:0]  cur_ff, cur_in;
   logic [TW-1:0]     dq_ff, dq_in;
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [SW-1:0]     step_ff, step_in;
   logic [CUR_W-1:0]  old_cur;
   logic              full;
   logic [FILL_W:0]   trial;
   logic              qbit;

   osma_ram #(.WIDTH(CUR_W), .DEPTH(DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (wp_ff),
      .wr_data (cur_ff),
      .rd_en   (pop),
      .rd_addr (wp_ff),
      .rd_data (old_cur)
   );

   assign full  = (count_ff == FILL_W'(DEPTH));
   assign pop   = (state_ff == ST_IDLE) && head.valid;
   assign trial = {rem_ff, dq_ff[TW-1]};
   assign qbit  = (trial >= {1'b0, count_ff});

   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      count_in = count_ff;
      total_in = total_ff;
      cur_in   = cur_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               cur_in   = head.current;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // Drop the overwritten entry once the ring is full, then add the new one.
            total_in = total_ff - (full ? TW'(old_cur) : '0) + TW'(cur_ff);
            wp_in    = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            if (!full) begin
               count_in = count_ff + 1'b1;
            end
            dq_in    = total_in;
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = qbit ? FILL_W'(trial - {1'b0, count_ff}) : trial[FILL_W-1:0];
            dq_in   = {dq_ff[TW-2:0], qbit};
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(TW - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign rsp_ch.valid           = (state_ff == ST_OUT);
   assign rsp_ch.sample_current  = cur_ff;
   assign rsp_ch.average_current = dq_ff[CUR_W-1:0];
   assign rsp_ch.fill_count      = count_ff;
endmodule

@@ hdl/osma_checker.sv @@
// Port-level checks for the offset-scaled moving average block, bound to the top.
// Depends on osma_pkg.
module osma_checker #(
   parameter int DEPTH  = osma_pkg::DEPTH_DEF,
   parameter int FILL_W = $clog2(DEPTH + 1)
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [osma_pkg::CUR_W-1:0]  sample_current,
   input logic [osma_pkg::CUR_W-1:0]  average_current,
   input logic [FILL_W-1:0]           fill_count
);
   import osma_pkg::*;

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_current)
         && $stable(average_current) && $stable(fill_count))
      else $error("result changed while stalled");

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every result counts at least its own sample and never more than the ring.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fill_count != '0 && fill_count <= FILL_W'(DEPTH))
      else $error("fill count out of range");

   // With one stored sample the mean is that sample.
   a_first_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fill_count == FILL_W'(1) |-> average_current == sample_current)
      else $error("mean of a single sample differs from it");
endmodule

bind offset_scaled_moving_average_core osma_checker #(.DEPTH(DEPTH)) u_osma_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .sample_current  (rsp_ch.sample_current),
   .average_current (rsp_ch.average_current),
   .fill_count      (rsp_ch.fill_count)
);
